>>> rtl/ppv_pkg.sv
// ----------------------------------------------------------------------------
// ppv_pkg: shared types and constants of the pure pursuit velocity unit
// Channel payloads, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ppv_pkg;

	// one pose to track toward an end point
	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic [15:0]        start_heading;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} pose_t;

	// one velocity command
	typedef struct packed {
		logic [30:0]        linear_speed;
		logic signed [31:0] turn_rate;
		logic               turning_in_place;
		logic               degenerate;
	} cmd_t;

	// register write
	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] wdata;
	} cfg_wr_t;

	typedef enum logic [2:0] {
		REG_LOOK_AHEAD      = 3'd0,
		REG_MAX_ACCEL       = 3'd1,
		REG_ANGLE_THRESHOLD = 3'd2,
		REG_MIN_SPEED       = 3'd3,
		REG_TURN_RATE_MIN   = 3'd4,
		REG_TURN_RATE_MAX   = 3'd5,
		REG_MAX_SPEED       = 3'd6
	} cfg_reg_t;

	localparam logic [30:0]        MAX31           = '1;
	localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
	localparam int                 NORM_BIT        = 40;

	// arctangent of 2^-idx as a 32-bit binary angle
	function automatic logic [31:0] cordic_atan(input int idx);
		logic [31:0] a;
		case (idx)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/ppv_stream_if.sv
// ----------------------------------------------------------------------------
// ppv_stream_if: valid/ready channel
// One transfer at each rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ppv_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/pure_pursuit_velocity_unit.sv
// ----------------------------------------------------------------------------
// pure_pursuit_velocity_unit: pure pursuit speed and turn-rate command
// Throughput: one pose per cycle while no command waits at the output, one command per pose, set by the cell chains.
// A waiting command holds the whole chain; the chain takes a pose in the cycle it is taken.
// Reset: arst_n clears all valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pure_pursuit_velocity_unit
	import ppv_pkg::*;
#(
	parameter int FRAC_BITS     = 16,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	ppv_stream_if.sink   pose,
	ppv_stream_if.source cmd,
	ppv_stream_if.sink   cfg
);

	localparam int F    = FRAC_BITS;
	localparam int A    = ANGLE_BITS;
	localparam int CS   = CORDIC_STAGES;
	localparam int NW   = 31 + F;
	localparam int HALF = (NW + 1) / 2;
	localparam int HI   = NW - HALF;
	localparam int PW   = 31 + NW;
	localparam int VW   = 46;
	localparam int RW   = 34;
	localparam int SW   = F + 4;
	localparam int QUART  = 1 << (A - 2);
	localparam int HALF_T = 1 << (A - 1);
	localparam int SBF  = 36 + NW;

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	logic [30:0]        look_ahead_q, max_accel_q, min_speed_q, max_speed_q;
	logic [15:0]        angle_threshold_q;
	logic signed [31:0] turn_rate_min_q, turn_rate_max_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_ahead_q      <= 31'd65536;
			max_accel_q       <= 31'd3857449;
			angle_threshold_q <= 16'd8192;
			min_speed_q       <= 31'd6554;
			turn_rate_min_q   <= -32'sd65536000;
			turn_rate_max_q   <= 32'sd65536000;
			max_speed_q       <= 31'd655360;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.data.index))
				REG_LOOK_AHEAD:      look_ahead_q      <= cfg.data.wdata[30:0];
				REG_MAX_ACCEL:       max_accel_q       <= cfg.data.wdata[30:0];
				REG_ANGLE_THRESHOLD: angle_threshold_q <= cfg.data.wdata[15:0];
				REG_MIN_SPEED:       min_speed_q       <= cfg.data.wdata[30:0];
				REG_TURN_RATE_MIN:   turn_rate_min_q   <= signed'(cfg.data.wdata);
				REG_TURN_RATE_MAX:   turn_rate_max_q   <= signed'(cfg.data.wdata);
				REG_MAX_SPEED:       max_speed_q       <= cfg.data.wdata[30:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: advance everything unless the output holds a command
	// ------------------------------------------------------------------
	logic en;
	logic vld_s8;

	assign en         = !vld_s8 || cmd.ready;
	assign pose.ready = en;

	// ------------------------------------------------------------------
	// stage 1: offsets to the end point
	// ------------------------------------------------------------------
	logic signed [33:0] dx_c, dy_c;
	logic               vld_s1, degen_s1;
	logic signed [33:0] dx_s1, dy_s1;
	logic [A-1:0]       hd_s1;

	assign dx_c = 34'(pose.data.goal_x) - 34'(pose.data.start_x);
	assign dy_c = 34'(pose.data.goal_y) - 34'(pose.data.start_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= dx_c;
			dy_s1    <= dy_c;
			degen_s1 <= (dx_c == '0) && (dy_c == '0);
			hd_s1    <= A'(pose.data.start_heading);
		end
	end

	// ------------------------------------------------------------------
	// normalizer chain
	// ------------------------------------------------------------------
	logic signed [VW-1:0] nx [0:6];
	logic signed [VW-1:0] ny [0:6];
	logic [A:0]           nsb [0:6];
	logic                 nv [0:6];

	assign nx[0]  = VW'(dx_s1);
	assign ny[0]  = VW'(dy_s1);
	assign nsb[0] = {degen_s1, hd_s1};
	assign nv[0]  = vld_s1;

	for (genvar k = 0; k < 6; k++) begin : g_norm
		ppv_norm_cell #(.W(VW), .K(32 >> k), .SBW(A + 1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(nv[k]), .x_i(nx[k]), .y_i(ny[k]), .sb_i(nsb[k]),
			.vld_o(nv[k+1]), .x_o(nx[k+1]), .y_o(ny[k+1]), .sb_o(nsb[k+1])
		);
	end

	// ------------------------------------------------------------------
	// bearing: vectoring chain
	// ------------------------------------------------------------------
	logic signed [VW-1:0] vx [0:CS];
	logic signed [VW-1:0] vy [0:CS];
	logic [31:0]          vz [0:CS];
	logic [A:0]           vsb [0:CS];
	logic                 vv [0:CS];
	logic signed [VW-1:0] nx2, ny2;

	// last doubling, then fold the left half plane
	always_comb begin
		nx2 = nx[6] <<< 1;
		ny2 = ny[6] <<< 1;
		if (nx2 < 0) begin
			vx[0] = -nx2;
			vy[0] = -ny2;
			vz[0] = 32'h8000_0000;
		end else begin
			vx[0] = nx2;
			vy[0] = ny2;
			vz[0] = 32'h0000_0000;
		end
	end

	assign vsb[0] = nsb[6];
	assign vv[0]  = nv[6];

	for (genvar i = 0; i < CS; i++) begin : g_vec
		ppv_cordic_cell #(.W(VW), .IDX(i), .VECTOR(1'b1), .SBW(A + 1)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(vv[i]), .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]), .sb_i(vsb[i]),
			.vld_o(vv[i+1]), .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1]), .sb_o(vsb[i+1])
		);
	end

	// ------------------------------------------------------------------
	// stage 2: relative bearing and turn-in-place decision
	// ------------------------------------------------------------------
	logic [31:0]  zr;
	logic [A-1:0] rel_c, mag_c;
	logic         vld_s2, inplace_s2, degen_s2;
	logic [A-1:0] phi_s2;

	always_comb begin
		zr    = vz[CS] + (32'd1 << (31 - A));
		rel_c = zr[31 -: A] - vsb[CS][A-1:0];
		mag_c = rel_c[A-1] ? A'(-rel_c) : rel_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vv[CS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s2     <= rel_c;
			inplace_s2 <= 32'(mag_c) > 32'(angle_threshold_q);
			degen_s2   <= vsb[CS][A];
		end
	end

	// ------------------------------------------------------------------
	// sine: rotating chain
	// ------------------------------------------------------------------
	logic signed [A:0]    pe, pf;
	logic signed [RW-1:0] rx [0:CS];
	logic signed [RW-1:0] ry [0:CS];
	logic [31:0]          rz [0:CS];
	logic [2:0]           rsb [0:CS];
	logic                 rv [0:CS];

	// fold into [-quarter, quarter]
	always_comb begin
		pe = (A + 1)'(signed'(phi_s2));
		if (pe > (A + 1)'(QUART)) begin
			pf = (A + 1)'(HALF_T) - pe;
		end else if (pe < -(A + 1)'(QUART)) begin
			pf = -(A + 1)'(HALF_T) - pe;
		end else begin
			pf = pe;
		end
	end

	assign rx[0]  = CORDIC_INV_GAIN;
	assign ry[0]  = '0;
	assign rz[0]  = 32'(pf) <<< (32 - A);
	assign rsb[0] = {degen_s2, inplace_s2, phi_s2[A-1]};
	assign rv[0]  = vld_s2;

	for (genvar i = 0; i < CS; i++) begin : g_rot
		ppv_cordic_cell #(.W(RW), .IDX(i), .VECTOR(1'b0), .SBW(3)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(rv[i]), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]), .sb_i(rsb[i]),
			.vld_o(rv[i+1]), .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1]), .sb_o(rsb[i+1])
		);
	end

	// ------------------------------------------------------------------
	// stage 3: operands of the first divide
	// ------------------------------------------------------------------
	logic signed [RW-1:0] yr;
	logic signed [SW-1:0] s_c;
	logic [SW-1:0]        as_c;
	logic                 vld_s3;
	logic [NW-1:0]        num_s3;
	logic [30:0]          d_s3;
	logic [2:0]           sb_s3;

	always_comb begin
		yr   = ry[CS] + (RW'(1) <<< (29 - F));
		s_c  = SW'(yr >>> (30 - F));
		as_c = s_c[SW-1] ? SW'(-s_c) : SW'(s_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= rv[CS];
		end
	end

	// in place: max_accel/min_speed; pursuit: |2 sin| / look_ahead
	always_ff @(posedge clk) begin
		if (en) begin
			if (rsb[CS][1]) begin
				num_s3 <= NW'(max_accel_q) << F;
				d_s3   <= min_speed_q;
				sb_s3  <= rsb[CS];
			end else begin
				num_s3 <= NW'(as_c) << (F + 1);
				d_s3   <= (look_ahead_q == '0) ? 31'd1 : look_ahead_q;
				sb_s3  <= {rsb[CS][2:1], s_c[SW-1]};
			end
		end
	end

	// ------------------------------------------------------------------
	// first divider chain
	// ------------------------------------------------------------------
	logic [NW-1:0] da [0:NW];
	logic [30:0]   dr [0:NW];
	logic [30:0]   dd [0:NW];
	logic [2:0]    dsb [0:NW];
	logic          dv [0:NW];

	assign da[0]  = num_s3;
	assign dr[0]  = '0;
	assign dd[0]  = d_s3;
	assign dsb[0] = sb_s3;
	assign dv[0]  = vld_s3;

	for (genvar i = 0; i < NW; i++) begin : g_div1
		ppv_div_cell #(.NW(NW), .DW(31), .SBW(3)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(dv[i]), .acc_i(da[i]), .rem_i(dr[i]), .d_i(dd[i]), .sb_i(dsb[i]),
			.vld_o(dv[i+1]), .acc_o(da[i+1]), .rem_o(dr[i+1]), .d_o(dd[i+1]),
			.sb_o(dsb[i+1])
		);
	end

	// ------------------------------------------------------------------
	// stage 4: clamp the turn-in-place rate, keep gamma
	// ------------------------------------------------------------------
	logic [NW-1:0]      q1;
	logic [30:0]        mag31;
	logic signed [31:0] mg, tip_c, tcl_c;
	logic               vld_s4;
	logic [SBF-1:0]     sb_s4;

	always_comb begin
		q1    = da[NW];
		mag31 = (q1 > NW'(MAX31)) ? MAX31 : q1[30:0];
		mg    = signed'({1'b0, mag31});
		tip_c = dsb[NW][0] ? -mg : mg;
		if (tip_c > turn_rate_max_q) begin
			tcl_c = turn_rate_max_q;
		end else if (tip_c < turn_rate_min_q) begin
			tcl_c = turn_rate_min_q;
		end else begin
			tcl_c = tip_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= dv[NW];
		end
	end

	// {degenerate, in place, negative, gamma zero, gamma, in-place rate}
	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4 <= {dsb[NW], q1 == '0, q1, tcl_c};
		end
	end

	// ------------------------------------------------------------------
	// stages 5 and 6: max_accel * gamma in two partial products, saturate
	// ------------------------------------------------------------------
	logic                 vld_s5, vld_s6;
	logic [30+HALF:0]     plo_s5;
	logic [30+HI:0]       phi_s5;
	logic [SBF-1:0]       sb_s5, sb_s6;
	logic [PW-1:0]        prod_c;
	logic [63:0]          prod_s6;

	assign prod_c = PW'(plo_s5) + (PW'(phi_s5) << HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s5  <= (31 + HALF)'(max_accel_q) * (31 + HALF)'(sb_s4[32 +: HALF]);
			phi_s5  <= (31 + HI)'(max_accel_q) * (31 + HI)'(sb_s4[32 + HALF +: HI]);
			sb_s5   <= sb_s4;
			prod_s6 <= (prod_c[PW-1:64] != '0) ? '1 : prod_c[63:0];
			sb_s6   <= sb_s5;
		end
	end

	// ------------------------------------------------------------------
	// square root chain
	// ------------------------------------------------------------------
	logic [63:0]    sv [0:32];
	logic [33:0]    srem [0:32];
	logic [31:0]    sroot [0:32];
	logic [SBF-1:0] ssb [0:32];
	logic           svl [0:32];

	assign sv[0]    = prod_s6;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign ssb[0]   = sb_s6;
	assign svl[0]   = vld_s6;

	for (genvar i = 0; i < 32; i++) begin : g_sqrt
		ppv_sqrt_cell #(.SBW(SBF)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(svl[i]), .v_i(sv[i]), .rem_i(srem[i]), .root_i(sroot[i]), .sb_i(ssb[i]),
			.vld_o(svl[i+1]), .v_o(sv[i+1]), .rem_o(srem[i+1]), .root_o(sroot[i+1]),
			.sb_o(ssb[i+1])
		);
	end

	// ------------------------------------------------------------------
	// stage 7: pursuit turn rate, operands of the second divide
	// ------------------------------------------------------------------
	logic [SBF-1:0]     sq;
	logic [30:0]        w31;
	logic signed [31:0] wm, tp_c, tf_c;
	logic               vld_s7;
	logic [NW-1:0]      num_s7, d_s7;
	logic [34:0]        sb_s7;

	always_comb begin
		sq   = ssb[32];
		w31  = sroot[32][31] ? MAX31 : sroot[32][30:0];
		wm   = signed'({1'b0, w31});
		tp_c = sq[33+NW] ? -wm : wm;
		if (sq[34+NW]) begin
			tf_c = signed'(sq[31:0]);
		end else if (sq[32+NW]) begin
			tf_c = '0;
		end else begin
			tf_c = tp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= svl[32];
		end
	end

	// {degenerate, in place, gamma zero, final rate}
	always_ff @(posedge clk) begin
		if (en) begin
			num_s7 <= NW'(w31) << F;
			d_s7   <= sq[32 +: NW];
			sb_s7  <= {sq[35+NW], sq[34+NW], sq[32+NW], tf_c};
		end
	end

	// ------------------------------------------------------------------
	// second divider chain: speed = w / gamma
	// ------------------------------------------------------------------
	logic [NW-1:0] ea [0:NW];
	logic [NW-1:0] er [0:NW];
	logic [NW-1:0] ed [0:NW];
	logic [34:0]   esb [0:NW];
	logic          ev [0:NW];

	assign ea[0]  = num_s7;
	assign er[0]  = '0;
	assign ed[0]  = d_s7;
	assign esb[0] = sb_s7;
	assign ev[0]  = vld_s7;

	for (genvar i = 0; i < NW; i++) begin : g_div2
		ppv_div_cell #(.NW(NW), .DW(NW), .SBW(35)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(ev[i]), .acc_i(ea[i]), .rem_i(er[i]), .d_i(ed[i]), .sb_i(esb[i]),
			.vld_o(ev[i+1]), .acc_o(ea[i+1]), .rem_o(er[i+1]), .d_o(ed[i+1]),
			.sb_o(esb[i+1])
		);
	end

	// ------------------------------------------------------------------
	// stage 8: output register
	// ------------------------------------------------------------------
	logic [34:0] eo;
	logic [30:0] spd_c;
	cmd_t        cmd_s8;

	always_comb begin
		eo = esb[NW];
		if (eo[34]) begin
			spd_c = '0;
		end else if (eo[33]) begin
			spd_c = min_speed_q;
		end else if (eo[32] || (ea[NW] > NW'(max_speed_q))) begin
			spd_c = max_speed_q;
		end else begin
			spd_c = ea[NW][30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= ev[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s8.linear_speed     <= spd_c;
			cmd_s8.turn_rate        <= eo[34] ? 32'sd0 : signed'(eo[31:0]);
			cmd_s8.turning_in_place <= !eo[34] && eo[33];
			cmd_s8.degenerate       <= eo[34];
		end
	end

	assign cmd.valid = vld_s8;
	assign cmd.data  = cmd_s8;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && !cmd.ready |-> !pose.ready)
		else $error("pose taken while a command is stalled");

	a_in_place_speed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.data.turning_in_place |-> cmd.data.linear_speed == min_speed_q)
		else $error("turn in place without min_speed");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.data.degenerate |->
			cmd.data.linear_speed == '0 && cmd.data.turn_rate == '0 &&
			!cmd.data.turning_in_place)
		else $error("degenerate command not zero");

	a_pursuit_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && !cmd.data.turning_in_place && !cmd.data.degenerate |->
			cmd.data.linear_speed <= max_speed_q)
		else $error("pursuit speed above max_speed");

endmodule

>>> rtl/ppv_norm_cell.sv
// ----------------------------------------------------------------------------
// ppv_norm_cell: one step of the vector normalizer
// Shifts (x, y) left by K when the larger magnitude is below 2^(40-K).
// ----------------------------------------------------------------------------
module ppv_norm_cell
	import ppv_pkg::*;
#(
	parameter int W   = 46,
	parameter int K   = 1,
	parameter int SBW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic [SBW-1:0]      sb_i,
	output logic                vld_o,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic [SBW-1:0]      sb_o
);

	logic [W-1:0] ax, ay, m;
	logic         shift;
	logic         vld_q;
	logic signed [W-1:0] x_q, y_q;
	logic [SBW-1:0] sb_q;

	// larger magnitude decides the shift
	always_comb begin
		ax    = x_i[W-1] ? W'(-x_i) : W'(x_i);
		ay    = y_i[W-1] ? W'(-y_i) : W'(y_i);
		m     = (ax > ay) ? ax : ay;
		shift = m < (W'(1) << (NORM_BIT - K));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q  <= shift ? (x_i <<< K) : x_i;
			y_q  <= shift ? (y_i <<< K) : y_i;
			sb_q <= sb_i;
		end
	end

	assign vld_o = vld_q;
	assign x_o   = x_q;
	assign y_o   = y_q;
	assign sb_o  = sb_q;

endmodule

>>> rtl/ppv_cordic_cell.sv
// ----------------------------------------------------------------------------
// ppv_cordic_cell: one CORDIC micro-rotation
// Vectoring mode drives y to zero, rotating mode drives z to zero.
// ----------------------------------------------------------------------------
module ppv_cordic_cell
	import ppv_pkg::*;
#(
	parameter int W      = 46,
	parameter int IDX    = 0,
	parameter bit VECTOR = 1'b1,
	parameter int SBW    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  logic signed [W-1:0] x_i,
	input  logic signed [W-1:0] y_i,
	input  logic [31:0]         z_i,
	input  logic [SBW-1:0]      sb_i,
	output logic                vld_o,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic [31:0]         z_o,
	output logic [SBW-1:0]      sb_o
);

	localparam logic [31:0] ATAN = cordic_atan(IDX);

	logic signed [W-1:0] xs, ys, x_n, y_n;
	logic [31:0]         z_n;
	logic                pos;
	logic                vld_q;
	logic signed [W-1:0] x_q, y_q;
	logic [31:0]         z_q;
	logic [SBW-1:0]      sb_q;

	// pick the rotation direction and rotate
	always_comb begin
		xs  = x_i >>> IDX;
		ys  = y_i >>> IDX;
		pos = VECTOR ? !(y_i > 0) : !z_i[31];
		if (pos) begin
			x_n = x_i - ys;
			y_n = y_i + xs;
			z_n = z_i - ATAN;
		end else begin
			x_n = x_i + ys;
			y_n = y_i - xs;
			z_n = z_i + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q  <= x_n;
			y_q  <= y_n;
			z_q  <= z_n;
			sb_q <= sb_i;
		end
	end

	assign vld_o = vld_q;
	assign x_o   = x_q;
	assign y_o   = y_q;
	assign z_o   = z_q;
	assign sb_o  = sb_q;

endmodule

>>> rtl/ppv_div_cell.sv
// ----------------------------------------------------------------------------
// ppv_div_cell: one bit of a restoring divider
// Brings down the next dividend bit and shifts in one quotient bit.
// ----------------------------------------------------------------------------
module ppv_div_cell #(
	parameter int NW  = 47,
	parameter int DW  = 31,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  logic [NW-1:0]  acc_i,
	input  logic [DW-1:0]  rem_i,
	input  logic [DW-1:0]  d_i,
	input  logic [SBW-1:0] sb_i,
	output logic           vld_o,
	output logic [NW-1:0]  acc_o,
	output logic [DW-1:0]  rem_o,
	output logic [DW-1:0]  d_o,
	output logic [SBW-1:0] sb_o
);

	logic [DW:0]    r2, sub;
	logic           ge;
	logic           vld_q;
	logic [NW-1:0]  acc_q;
	logic [DW-1:0]  rem_q, d_q;
	logic [SBW-1:0] sb_q;

	// trial subtract
	always_comb begin
		r2  = {rem_i, acc_i[NW-1]};
		sub = r2 - {1'b0, d_i};
		ge  = r2 >= {1'b0, d_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? sub[DW-1:0] : r2[DW-1:0];
			acc_q <= {acc_i[NW-2:0], ge};
			d_q   <= d_i;
			sb_q  <= sb_i;
		end
	end

	assign vld_o = vld_q;
	assign acc_o = acc_q;
	assign rem_o = rem_q;
	assign d_o   = d_q;
	assign sb_o  = sb_q;

endmodule

>>> rtl/ppv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ppv_sqrt_cell: one root bit of a digit-by-digit integer square root
// Takes the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module ppv_sqrt_cell #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  logic [63:0]    v_i,
	input  logic [33:0]    rem_i,
	input  logic [31:0]    root_i,
	input  logic [SBW-1:0] sb_i,
	output logic           vld_o,
	output logic [63:0]    v_o,
	output logic [33:0]    rem_o,
	output logic [31:0]    root_o,
	output logic [SBW-1:0] sb_o
);

	logic [35:0]    r2, trial, sub;
	logic           ge;
	logic           vld_q;
	logic [63:0]    v_q;
	logic [33:0]    rem_q;
	logic [31:0]    root_q;
	logic [SBW-1:0] sb_q;

	// compare against 4*root + 1
	always_comb begin
		r2    = {rem_i, v_i[63:62]};
		trial = {2'b00, root_i, 2'b01};
		sub   = r2 - trial;
		ge    = r2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? sub[33:0] : r2[33:0];
			root_q <= {root_i[30:0], ge};
			v_q    <= {v_i[61:0], 2'b00};
			sb_q   <= sb_i;
		end
	end

	assign vld_o  = vld_q;
	assign v_o    = v_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign sb_o   = sb_q;

endmodule

>>> test/pure_pursuit_velocity_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pure_pursuit_velocity_unit_tb: self-checking bench of the pure pursuit unit
// Sends poses through the pose channel under several register settings.
// Checks every command, field by field, against a bit-exact predictor of the
// CORDIC bearing, sine and square-root datapath. Both channels idle at random.
// ----------------------------------------------------------------------------
module pure_pursuit_velocity_unit_tb;
	import ppv_pkg::*;

	localparam int HALF_TURN   = 32768;
	localparam int QUART_TURN  = 16384;
	localparam int HOLD_CYCLES = 400;
	localparam int WDOG_LIMIT  = 3000;
	localparam int DRAIN       = 200;
	localparam int N_DIR       = 18;
	localparam int N_PHASE     = 7;
	localparam int PER_PHASE   = 100;
	localparam logic [63:0] ROOT_TOP = 64'h4000_0000_0000_0000;

	typedef struct {
		pose_t p;
		bit    typed;
		cmd_t  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppv_stream_if #(.T(pose_t))   pose_ch ();
	ppv_stream_if #(.T(cmd_t))    cmd_ch ();
	ppv_stream_if #(.T(cfg_wr_t)) cfg_ch ();

	pure_pursuit_velocity_unit i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pose  (pose_ch),
		.cmd   (cmd_ch),
		.cfg   (cfg_ch)
	);

	always #5 clk = ~clk;

	// register shadow
	logic [30:0] la_r, acc_r, mins_r, maxs_r;
	logic [15:0] thr_r;
	longint      trmin_r, trmax_r;

	cmd_t cmd_q[$];
	int   n_err = 0;
	int   n_cmds = 0, n_in_place = 0, n_degen = 0, n_straight = 0;
	int   n_poses = 0;
	bit   quiet = 1'b0;
	int   hold_reqs = 0, hold_seen = 0, hold_left = 0;
	int   idle_cycles = 0;

	// ---------------- predictor ----------------
	function automatic logic [31:0] atan_ba(int i);
		return cordic_atan(i);
	endfunction

	function automatic logic [63:0] root_trunc(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = ROOT_TOP;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] bearing_ba(longint dx, longint dy);
		longint      x, y, nx;
		logic [63:0] m, mx, my;
		logic [31:0] z;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		m = mx > my ? mx : my;
		z = 0;
		while (m < (64'd1 << NORM_BIT)) begin
			dx = dx * 2;
			dy = dy * 2;
			m = m * 2;
		end
		if (dx < 0) begin
			x = -dx;
			y = -dy;
			z = 32'h8000_0000;
		end else begin
			x = dx;
			y = dy;
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_ba(i);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_ba(i);
			end
			x = nx;
		end
		z = z + (32'd1 << 15);
		return z[31:16];
	endfunction

	function automatic longint sine_q16(longint phi);
		longint x, y, z, nx;
		x = 652032874;
		y = 0;
		if (phi > QUART_TURN) phi = HALF_TURN - phi;
		else if (phi < -QUART_TURN) phi = -HALF_TURN - phi;
		z = phi * 65536;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(atan_ba(i));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(atan_ba(i));
			end
			x = nx;
		end
		return (y + (64'sd1 <<< 13)) >>> 14;
	endfunction

	function automatic cmd_t pursuit_cmd(pose_t p);
		cmd_t        c;
		longint      dx, dy, phi, s, turn;
		logic [15:0] rel;
		logic [63:0] mag, l, g, prod, w, spd;
		c = '0;
		dx = longint'(p.goal_x) - longint'(p.start_x);
		dy = longint'(p.goal_y) - longint'(p.start_y);
		if (dx == 0 && dy == 0) begin
			c.degenerate = 1'b1;
			return c;
		end
		rel = bearing_ba(dx, dy) - p.start_heading;
		phi = rel;
		if (phi >= HALF_TURN) phi = phi - 2 * HALF_TURN;
		mag = phi < 0 ? -phi : phi;
		if (mag > thr_r) begin
			c.turning_in_place = 1'b1;
			spd = mins_r;
			if (mins_r == 0) mag = MAX31;
			else mag = (64'(acc_r) << 16) / mins_r;
			if (mag > MAX31) mag = MAX31;
			turn = phi >= 0 ? longint'(mag) : -longint'(mag);
			if (turn > trmax_r) turn = trmax_r;
			else if (turn < trmin_r) turn = trmin_r;
		end else begin
			s = sine_q16(phi);
			l = la_r != 0 ? 64'(la_r) : 64'd1;
			g = ((64'(s < 0 ? -s : s) * 2) << 16) / l;
			if (g == 0) begin
				spd = maxs_r;
				turn = 0;
			end else begin
				if (acc_r != 0 && g > 64'hFFFF_FFFF_FFFF_FFFF / acc_r)
					prod = 64'hFFFF_FFFF_FFFF_FFFF;
				else
					prod = 64'(acc_r) * g;
				w = root_trunc(prod);
				if (w > MAX31) w = MAX31;
				spd = (w << 16) / g;
				if (spd > maxs_r) spd = maxs_r;
				turn = s < 0 ? -longint'(w) : longint'(w);
			end
		end
		c.linear_speed = spd[30:0];
		c.turn_rate = turn[31:0];
		return c;
	endfunction

	// ---------------- register writes ----------------
	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, wdata: v};
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_LOOK_AHEAD:      la_r = v[30:0];
			REG_MAX_ACCEL:       acc_r = v[30:0];
			REG_ANGLE_THRESHOLD: thr_r = v[15:0];
			REG_MIN_SPEED:       mins_r = v[30:0];
			REG_TURN_RATE_MIN:   trmin_r = longint'(signed'(v));
			REG_TURN_RATE_MAX:   trmax_r = longint'(signed'(v));
			REG_MAX_SPEED:       maxs_r = v[30:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] la, logic [31:0] acc, logic [31:0] thr,
			logic [31:0] mins, logic [31:0] trmin, logic [31:0] trmax, logic [31:0] maxs);
		write_reg(REG_LOOK_AHEAD, la);
		write_reg(REG_MAX_ACCEL, acc);
		write_reg(REG_ANGLE_THRESHOLD, thr);
		write_reg(REG_MIN_SPEED, mins);
		write_reg(REG_TURN_RATE_MIN, trmin);
		write_reg(REG_TURN_RATE_MAX, trmax);
		write_reg(REG_MAX_SPEED, maxs);
		cfg_ch.valid <= 1'b0;
	endtask

	// ---------------- pose sender ----------------
	task automatic send_pose(pose_t p, bit typed, cmd_t want);
		while (!quiet && $urandom_range(99) < 8) begin
			pose_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pose_ch.valid <= 1'b1;
		pose_ch.data <= p;
		do @(posedge clk); while (!pose_ch.ready);
		cmd_q.push_back(typed ? want : pursuit_cmd(p));
		n_poses++;
	endtask

	task automatic wait_drained();
		pose_ch.valid <= 1'b0;
		while (cmd_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// random pose: mostly aimed near the bearing so both branches are reached
	function automatic pose_t rand_pose();
		pose_t  p;
		longint dx, dy;
		int     mode;
		p.start_x = $urandom;
		p.start_y = $urandom;
		p.start_heading = $urandom;
		mode = $urandom_range(9);
		if (mode < 3) begin
			p.goal_x = $urandom;
			p.goal_y = $urandom;
		end else if (mode < 8) begin
			p.goal_x = p.start_x + int'($urandom_range(2000)) - 1000;
			p.goal_y = p.start_y + int'($urandom_range(2000)) - 1000;
			if ($urandom_range(3) == 0) p.goal_x = p.start_x + (int'($urandom) >>> 8);
		end else if (mode == 8) begin
			p.goal_x = p.start_x;
			p.goal_y = $urandom_range(1) ? p.start_y : p.start_y + 1;
		end else begin
			p.goal_x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			p.goal_y = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		dx = longint'(p.goal_x) - longint'(p.start_x);
		dy = longint'(p.goal_y) - longint'(p.start_y);
		if ((dx != 0 || dy != 0) && $urandom_range(9) < 6)
			p.start_heading = bearing_ba(dx, dy)
				+ 16'($urandom_range(2 * thr_r + 64) - thr_r - 32);
		return p;
	endfunction

	// ---------------- command checker ----------------
	always @(posedge clk or negedge arst_n) begin
		cmd_t e;
		if (!arst_n) begin
			cmd_ch.ready <= 1'b0;
		end else begin
			// hold off on request, else idle at random
			if (hold_reqs != hold_seen) begin
				hold_seen <= hold_reqs;
				hold_left <= HOLD_CYCLES;
				cmd_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= quiet || $urandom_range(99) >= 8;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				n_cmds++;
				if (cmd_q.size() == 0) begin
					n_err++;
					if (n_err <= 10) $display("ERROR: command with nothing expected: %p", cmd_ch.data);
				end else begin
					e = cmd_q.pop_front();
					n_in_place += e.turning_in_place;
					n_degen += e.degenerate;
					n_straight += (!e.degenerate && !e.turning_in_place && e.turn_rate == 0);
					if (cmd_ch.data.linear_speed != e.linear_speed
							|| cmd_ch.data.turn_rate != e.turn_rate
							|| cmd_ch.data.turning_in_place != e.turning_in_place
							|| cmd_ch.data.degenerate != e.degenerate) begin
						n_err++;
						if (n_err <= 10)
							$display("ERROR: cmd %0d speed %0d/%0d turn %0d/%0d inplace %0b/%0b degen %0b/%0b (exp/act)",
								n_cmds, e.linear_speed, cmd_ch.data.linear_speed,
								e.turn_rate, cmd_ch.data.turn_rate,
								e.turning_in_place, cmd_ch.data.turning_in_place,
								e.degenerate, cmd_ch.data.degenerate);
					end
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	dir_row_t dir_tab[N_DIR];
	cmd_t     degen_cmd;

	initial begin
		pose_t p;
		degen_cmd = '{linear_speed: '0, turn_rate: '0, turning_in_place: 1'b0, degenerate: 1'b1};
		dir_tab = '{
			'{'{32'sd0, 32'sd0, 16'h0000, 32'sd0, 32'sd0}, 1'b1, degen_cmd},
			'{'{32'h8000_0000, 32'h8000_0000, 16'h1234, 32'h8000_0000, 32'h8000_0000},
				1'b1, degen_cmd},
			'{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
				1'b1, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h0000, 32'sd65536, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h8000, -32'sd65536, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h4000, 32'sd0, 32'sd65536}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'hC000, 32'sd0, -32'sd65536}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h8000, 32'sd65536, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h2000, 32'sd65536, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'hE000, 32'sd65536, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h0001, 32'sd1, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd5, 32'sd5, 16'h2000, 32'sd6, 32'sd6}, 1'b0, degen_cmd},
			'{'{32'h8000_0000, 32'h8000_0000, 16'h2000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
				1'b0, degen_cmd},
			'{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hA000, 32'h8000_0000, 32'h8000_0000},
				1'b0, degen_cmd},
			'{'{32'h8000_0000, 32'sd0, 16'h0000, 32'h7FFF_FFFF, 32'sd0}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'h7FFF_FFFF, 16'hC000, 32'sd0, 32'h8000_0000}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'hFFFF, 32'sd100, -32'sd1}, 1'b0, degen_cmd},
			'{'{32'sd0, 32'sd0, 16'h0000, -32'sd1, 32'sd0}, 1'b0, degen_cmd}
		};
		la_r = 31'd65536;
		acc_r = 31'd3857449;
		thr_r = 16'd8192;
		mins_r = 31'd6554;
		trmin_r = -65536000;
		trmax_r = 65536000;
		maxs_r = 31'd655360;
		pose_ch.valid = 1'b0;
		pose_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed poses under reset defaults
		foreach (dir_tab[i]) send_pose(dir_tab[i].p, dir_tab[i].typed, dir_tab[i].want);
		wait_drained();

		for (int ph = 0; ph < N_PHASE; ph++) begin
			case (ph)
				0: ; // reset defaults
				1: write_all(32'd1, 32'h7FFF_FFFF, 32'd0, 32'd1,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				2: write_all(32'h7FFF_FFFF, 32'd1, 32'd32768, 32'h7FFF_FFFF,
					32'd0, 32'd0, 32'd0);
				3: write_all(32'd0, 32'd0, 32'd65535, 32'd0,
					32'd1000, -32'sd1000, 32'd65536);
				4: write_all(32'd32768, 32'd1000000, 32'd4000, 32'd0,
					32'd5000000, -32'sd5000000, 32'd1000000);
				5: write_all($urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF,
					$urandom_range(32768), $urandom & 32'h7FFF_FFFF,
					$urandom, $urandom, $urandom & 32'h7FFF_FFFF);
				default: write_all(32'd131072, 32'd3857449, 32'd12000, 32'd6554,
					-32'sd65536000, 32'sd65536000, 32'd655360);
			endcase
			// long receiver hold-off with the sender streaming back to back,
			// enough poses to fill the chain and stall the input
			quiet = (ph == 2);
			if (ph == 2) hold_reqs++;
			for (int k = 0; k < ((ph == 2) ? 3 * PER_PHASE : PER_PHASE); k++) begin
				if (ph == 4 && k == PER_PHASE / 2) wait_drained();
				p = rand_pose();
				send_pose(p, 1'b0, degen_cmd);
			end
			quiet = 1'b0;
			wait_drained();
		end

		repeat (DRAIN) @(posedge clk);
		$display("Run covered %0d poses in %0d register settings: %0d commands, %0d in place,",
			n_poses, N_PHASE, n_cmds, n_in_place);
		$display("%0d coincident points, %0d straight ahead; %0d mismatches.",
			n_degen, n_straight, n_err);
		if (n_err == 0 && cmd_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ppv_pkg.sv
rtl/ppv_stream_if.sv
rtl/ppv_norm_cell.sv
rtl/ppv_cordic_cell.sv
rtl/ppv_div_cell.sv
rtl/ppv_sqrt_cell.sv
rtl/pure_pursuit_velocity_unit.sv
test/pure_pursuit_velocity_unit_tb.sv
